### hw/rtl/mlad_pkg.sv
// Package with shared constants, types and control structs of the member list difference block.
package mlad_pkg;

    localparam int MEMBER_MAX = 32;
    localparam int UID_W      = 32;
    localparam int OP_W       = 2;
    localparam int KIND_W     = 2;
    localparam int CNT_W      = $clog2(MEMBER_MAX + 1);
    localparam int ADDR_W     = $clog2(MEMBER_MAX);
    localparam int TOT_W      = $clog2(2 * MEMBER_MAX + 1);

    localparam logic [UID_W-1:0] RESERVED_UID = '1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_OLD = 2'd0,
        OP_LOAD_NEW = 2'd1,
        OP_COMPUTE  = 2'd2
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_DELETE = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_START,
        ST_SORT_WAIT,
        ST_SORT_CMP,
        ST_SORT_FLUSH,
        ST_MRG_WAIT,
        ST_MRG_CMP,
        ST_NONE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MODE_COUNT,
        MODE_DEL,
        MODE_ADD
    } t_mode;

    typedef struct packed {
        logic              load_en;
        logic [UID_W-1:0]  load_uid;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [UID_W-1:0]  wr_data;
        logic [ADDR_W-1:0] rd_addr;
        logic              clear;
    } t_list_ctl;

    typedef struct packed {
        logic             lt;
        logic             gt;
        logic [UID_W-1:0] min;
        logic [UID_W-1:0] max;
    } t_cmp_res;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [UID_W-1:0]  uid;
        logic              overflowed;
        logic              last;
    } t_emit;

endpackage

### hw/rtl/mlad_if.sv
// Handshake interfaces for the request and result channels of the member list difference block.
interface mlad_in_if;
    logic                        valid;
    logic                        ready;
    logic [mlad_pkg::OP_W-1:0]   operation;
    logic [mlad_pkg::UID_W-1:0]  member_uid;

    modport source (output valid, output operation, output member_uid, input ready);
    modport sink (input valid, input operation, input member_uid, output ready);
endinterface

interface mlad_out_if;
    logic                         valid;
    logic                         ready;
    logic [mlad_pkg::KIND_W-1:0]  change_kind;
    logic [mlad_pkg::UID_W-1:0]   changed_uid;
    logic                         overflowed;
    logic                         last_result;

    modport source (output valid, output change_kind, output changed_uid, output overflowed,
                    output last_result, input ready);
    modport sink (input valid, input change_kind, input changed_uid, input overflowed,
                  input last_result, output ready);
endinterface

### hw/rtl/mlad_list.sv
// One member id list: memory with a single write port, a registered read port and a fill count.
module mlad_list (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mlad_pkg::t_list_ctl           i_ctl,
    output logic [mlad_pkg::UID_W-1:0]    o_rd_data,
    output logic [mlad_pkg::CNT_W-1:0]    o_count
);

    logic [mlad_pkg::UID_W-1:0]  r_mem [mlad_pkg::MEMBER_MAX];
    logic [mlad_pkg::UID_W-1:0]  r_rd_data;
    logic [mlad_pkg::CNT_W-1:0]  r_count;
    logic [mlad_pkg::CNT_W-1:0]  n_count;
    logic                        w_append;
    logic                        w_we;
    logic [mlad_pkg::ADDR_W-1:0] w_waddr;
    logic [mlad_pkg::UID_W-1:0]  w_wdata;

    assign w_append = i_ctl.load_en && (r_count != mlad_pkg::CNT_W'(mlad_pkg::MEMBER_MAX));

    always_comb begin
        w_we    = w_append || i_ctl.wr_en;
        w_waddr = w_append ? r_count[mlad_pkg::ADDR_W-1:0] : i_ctl.wr_addr;
        w_wdata = w_append ? i_ctl.load_uid : i_ctl.wr_data;
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (w_append) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_mem[i_ctl.rd_addr];
    end

    assign o_rd_data = r_rd_data;
    assign o_count   = r_count;

endmodule

### hw/rtl/mlad_cmp.sv
// Shared unsigned compare unit that also selects the smaller and the larger operand.
module mlad_cmp (
    input  logic [mlad_pkg::UID_W-1:0] i_a,
    input  logic [mlad_pkg::UID_W-1:0] i_b,
    output mlad_pkg::t_cmp_res         o_res
);

    always_comb begin
        o_res.lt  = i_a < i_b;
        o_res.gt  = i_a > i_b;
        o_res.min = (i_a < i_b) ? i_a : i_b;
        o_res.max = (i_a < i_b) ? i_b : i_a;
    end

endmodule

### hw/rtl/mlad_seq.sv
// Sequencer that loads both lists, bubble sorts them and walks them in merge order.
module mlad_seq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [mlad_pkg::OP_W-1:0]    i_op,
    input  logic [mlad_pkg::UID_W-1:0]   i_uid,
    output logic                         o_in_ready,
    input  logic [mlad_pkg::UID_W-1:0]   i_old_data,
    input  logic [mlad_pkg::UID_W-1:0]   i_new_data,
    input  logic [mlad_pkg::CNT_W-1:0]   i_old_cnt,
    input  logic [mlad_pkg::CNT_W-1:0]   i_new_cnt,
    output mlad_pkg::t_list_ctl          o_old_ctl,
    output mlad_pkg::t_list_ctl          o_new_ctl,
    output logic [mlad_pkg::UID_W-1:0]   o_cmp_a,
    output logic [mlad_pkg::UID_W-1:0]   o_cmp_b,
    input  mlad_pkg::t_cmp_res           i_cmp,
    output mlad_pkg::t_emit              o_emit,
    input  logic                         i_emit_ready
);

    mlad_pkg::t_state            r_state;
    mlad_pkg::t_state            n_state;
    mlad_pkg::t_mode             r_mode;
    mlad_pkg::t_mode             n_mode;
    logic                        r_sel;
    logic                        n_sel;
    logic [mlad_pkg::CNT_W-1:0]  r_pass;
    logic [mlad_pkg::CNT_W-1:0]  n_pass;
    logic [mlad_pkg::CNT_W-1:0]  r_k;
    logic [mlad_pkg::CNT_W-1:0]  n_k;
    logic [mlad_pkg::CNT_W-1:0]  r_i;
    logic [mlad_pkg::CNT_W-1:0]  n_i;
    logic [mlad_pkg::CNT_W-1:0]  r_j;
    logic [mlad_pkg::CNT_W-1:0]  n_j;
    logic [mlad_pkg::TOT_W-1:0]  r_total;
    logic [mlad_pkg::TOT_W-1:0]  n_total;
    logic [mlad_pkg::TOT_W-1:0]  r_emitted;
    logic [mlad_pkg::TOT_W-1:0]  n_emitted;
    logic [mlad_pkg::UID_W-1:0]  r_carry;
    logic [mlad_pkg::UID_W-1:0]  n_carry;
    logic                        r_overflow;
    logic                        n_overflow;

    logic                        w_acc;
    logic                        w_compute;
    logic                        w_load_old;
    logic                        w_load_new;
    logic                        w_sorting;
    logic [mlad_pkg::CNT_W-1:0]  w_sel_cnt;
    logic [mlad_pkg::UID_W-1:0]  w_sel_data;
    logic                        w_k_last;
    logic                        w_pass_last;
    logic                        w_old_has;
    logic                        w_new_has;
    logic                        w_take_old;
    logic                        w_take_new;
    logic                        w_merge_end;
    logic                        w_want_emit;
    logic                        w_stall;
    logic                        w_sort_wr;
    logic [mlad_pkg::ADDR_W-1:0] w_sort_waddr;
    logic [mlad_pkg::UID_W-1:0]  w_sort_wdata;

    always_comb begin
        w_acc        = i_in_valid && o_in_ready;
        w_compute    = w_acc && (i_op == mlad_pkg::OP_COMPUTE);
        w_load_old   = w_acc && (i_op == mlad_pkg::OP_LOAD_OLD)
                       && (i_uid != mlad_pkg::RESERVED_UID);
        w_load_new   = w_acc && (i_op == mlad_pkg::OP_LOAD_NEW)
                       && (i_uid != mlad_pkg::RESERVED_UID);
        w_sorting    = (r_state == mlad_pkg::ST_SORT_START) || (r_state == mlad_pkg::ST_SORT_WAIT)
                       || (r_state == mlad_pkg::ST_SORT_CMP) || (r_state == mlad_pkg::ST_SORT_FLUSH);
        w_sel_cnt    = r_sel ? i_new_cnt : i_old_cnt;
        w_sel_data   = r_sel ? i_new_data : i_old_data;
        w_k_last     = (r_k == w_sel_cnt - 1'b1);
        w_pass_last  = (r_pass + 1'b1) == (w_sel_cnt - 1'b1);
        w_old_has    = r_i < i_old_cnt;
        w_new_has    = r_j < i_new_cnt;
        w_take_old   = w_old_has && (!w_new_has || i_cmp.lt);
        w_take_new   = w_new_has && (!w_old_has || i_cmp.gt);
        w_merge_end  = !w_old_has && !w_new_has;
        w_want_emit  = (r_state == mlad_pkg::ST_MRG_CMP) && !w_merge_end
                       && (((r_mode == mlad_pkg::MODE_DEL) && w_take_old)
                           || ((r_mode == mlad_pkg::MODE_ADD) && w_take_new));
        w_stall      = w_want_emit && !i_emit_ready;
        w_sort_wr    = ((r_state == mlad_pkg::ST_SORT_CMP) && (r_k != '0))
                       || (r_state == mlad_pkg::ST_SORT_FLUSH);
        w_sort_waddr = (r_state == mlad_pkg::ST_SORT_FLUSH)
                       ? mlad_pkg::ADDR_W'(w_sel_cnt - 1'b1)
                       : mlad_pkg::ADDR_W'(r_k - 1'b1);
        w_sort_wdata = (r_state == mlad_pkg::ST_SORT_FLUSH) ? r_carry : i_cmp.min;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlad_pkg::ST_IDLE: begin
                if (w_compute) begin
                    if (i_new_cnt == '0) begin
                        n_state = mlad_pkg::ST_NONE;
                    end else if ((i_old_cnt > 1) || (i_new_cnt > 1)) begin
                        n_state = mlad_pkg::ST_SORT_START;
                    end else begin
                        n_state = mlad_pkg::ST_MRG_WAIT;
                    end
                end
            end
            mlad_pkg::ST_SORT_START: n_state = mlad_pkg::ST_SORT_WAIT;
            mlad_pkg::ST_SORT_WAIT:  n_state = mlad_pkg::ST_SORT_CMP;
            mlad_pkg::ST_SORT_CMP: begin
                n_state = w_k_last ? mlad_pkg::ST_SORT_FLUSH : mlad_pkg::ST_SORT_WAIT;
            end
            mlad_pkg::ST_SORT_FLUSH: begin
                if (!w_pass_last) begin
                    n_state = mlad_pkg::ST_SORT_START;
                end else if (!r_sel && (i_new_cnt > 1)) begin
                    n_state = mlad_pkg::ST_SORT_START;
                end else begin
                    n_state = mlad_pkg::ST_MRG_WAIT;
                end
            end
            mlad_pkg::ST_MRG_WAIT: n_state = mlad_pkg::ST_MRG_CMP;
            mlad_pkg::ST_MRG_CMP: begin
                if (w_merge_end) begin
                    if ((r_mode == mlad_pkg::MODE_ADD)
                        || ((r_mode == mlad_pkg::MODE_COUNT) && (r_total == '0))) begin
                        n_state = mlad_pkg::ST_DONE;
                    end else begin
                        n_state = mlad_pkg::ST_MRG_WAIT;
                    end
                end else if (!w_stall) begin
                    n_state = mlad_pkg::ST_MRG_WAIT;
                end
            end
            mlad_pkg::ST_NONE: begin
                if (i_emit_ready) begin
                    n_state = mlad_pkg::ST_DONE;
                end
            end
            mlad_pkg::ST_DONE: n_state = mlad_pkg::ST_IDLE;
            default: n_state = mlad_pkg::ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_comb begin
        n_mode     = r_mode;
        n_sel      = r_sel;
        n_pass     = r_pass;
        n_k        = r_k;
        n_i        = r_i;
        n_j        = r_j;
        n_total    = r_total;
        n_emitted  = r_emitted;
        n_carry    = r_carry;
        n_overflow = r_overflow;
        case (r_state)
            mlad_pkg::ST_IDLE: begin
                if ((w_load_old && (i_old_cnt == mlad_pkg::CNT_W'(mlad_pkg::MEMBER_MAX)))
                    || (w_load_new && (i_new_cnt == mlad_pkg::CNT_W'(mlad_pkg::MEMBER_MAX)))) begin
                    n_overflow = 1'b1;
                end
                if (w_compute) begin
                    n_sel     = !(i_old_cnt > 1);
                    n_pass    = '0;
                    n_mode    = mlad_pkg::MODE_COUNT;
                    n_i       = '0;
                    n_j       = '0;
                    n_total   = '0;
                    n_emitted = '0;
                end
            end
            mlad_pkg::ST_SORT_START: n_k = '0;
            mlad_pkg::ST_SORT_CMP: begin
                n_carry = (r_k == '0) ? w_sel_data : i_cmp.max;
                if (!w_k_last) begin
                    n_k = r_k + 1'b1;
                end
            end
            mlad_pkg::ST_SORT_FLUSH: begin
                if (!w_pass_last) begin
                    n_pass = r_pass + 1'b1;
                end else begin
                    n_sel  = 1'b1;
                    n_pass = '0;
                end
            end
            mlad_pkg::ST_MRG_CMP: begin
                if (w_merge_end) begin
                    n_i = '0;
                    n_j = '0;
                    n_mode = (r_mode == mlad_pkg::MODE_COUNT) ? mlad_pkg::MODE_DEL
                                                              : mlad_pkg::MODE_ADD;
                end else if (!w_stall) begin
                    if (w_take_old) begin
                        n_i = r_i + 1'b1;
                    end else if (w_take_new) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = r_j + 1'b1;
                    end
                    if ((r_mode == mlad_pkg::MODE_COUNT) && (w_take_old || w_take_new)) begin
                        n_total = r_total + 1'b1;
                    end
                    if (w_want_emit) begin
                        n_emitted = r_emitted + 1'b1;
                    end
                end
            end
            mlad_pkg::ST_DONE: n_overflow = 1'b0;
            default: begin
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready = (r_state == mlad_pkg::ST_IDLE);

        o_old_ctl.load_en  = w_load_old;
        o_old_ctl.load_uid = i_uid;
        o_old_ctl.wr_en    = w_sort_wr && !r_sel;
        o_old_ctl.wr_addr  = w_sort_waddr;
        o_old_ctl.wr_data  = w_sort_wdata;
        o_old_ctl.rd_addr  = (w_sorting && !r_sel) ? r_k[mlad_pkg::ADDR_W-1:0]
                                                   : r_i[mlad_pkg::ADDR_W-1:0];
        o_old_ctl.clear    = (r_state == mlad_pkg::ST_DONE);

        o_new_ctl.load_en  = w_load_new;
        o_new_ctl.load_uid = i_uid;
        o_new_ctl.wr_en    = w_sort_wr && r_sel;
        o_new_ctl.wr_addr  = w_sort_waddr;
        o_new_ctl.wr_data  = w_sort_wdata;
        o_new_ctl.rd_addr  = (w_sorting && r_sel) ? r_k[mlad_pkg::ADDR_W-1:0]
                                                  : r_j[mlad_pkg::ADDR_W-1:0];
        o_new_ctl.clear    = (r_state == mlad_pkg::ST_DONE);

        o_cmp_a = w_sorting ? r_carry : i_old_data;
        o_cmp_b = w_sorting ? w_sel_data : i_new_data;

        o_emit.overflowed = r_overflow;
        if (r_state == mlad_pkg::ST_NONE) begin
            o_emit.valid = 1'b1;
            o_emit.kind  = mlad_pkg::KIND_NONE;
            o_emit.uid   = '0;
            o_emit.last  = 1'b1;
        end else begin
            o_emit.valid = w_want_emit;
            o_emit.kind  = (r_mode == mlad_pkg::MODE_DEL) ? mlad_pkg::KIND_DELETE
                                                          : mlad_pkg::KIND_ADD;
            o_emit.uid   = (r_mode == mlad_pkg::MODE_DEL) ? i_old_data : i_new_data;
            o_emit.last  = (r_emitted + 1'b1) == r_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mlad_pkg::ST_IDLE;
            r_mode     <= mlad_pkg::MODE_COUNT;
            r_sel      <= 1'b0;
            r_pass     <= '0;
            r_k        <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_total    <= '0;
            r_emitted  <= '0;
            r_overflow <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_mode     <= n_mode;
            r_sel      <= n_sel;
            r_pass     <= n_pass;
            r_k        <= n_k;
            r_i        <= n_i;
            r_j        <= n_j;
            r_total    <= n_total;
            r_emitted  <= n_emitted;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
    end

`ifndef NO_ASSERTIONS
    a_lists_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlad_pkg::ST_DONE) |=> ((i_old_cnt == '0) && (i_new_cnt == '0)))
        else $error("lists not cleared after a compute run");

    a_emit_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= r_total)
        else $error("more results given than counted");

    a_sort_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mlad_pkg::ST_SORT_CMP) |-> (r_k < w_sel_cnt))
        else $error("sort index beyond list fill");

    a_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit.valid && i_emit_ready && o_emit.last && (r_state == mlad_pkg::ST_MRG_CMP))
        |=> (r_emitted == r_total))
        else $error("last result flagged before the final result");
`endif

endmodule

### hw/rtl/member_list_add_delete_diff_top.sv
// A load request is taken whenever the block is idle; a compute request holds ready low until done.
// Each list of n ids is bubble sorted through one shared comparator.
// The merge then runs up to three passes (count, deletes, adds), each step through a wait and a
// compare state, and output stalls can hold a step; an empty new list skips the sort and merge.
// Reset clears the fill counts, the overflow flag, the sequencer and the output valid flag;
// list contents are undefined until written and need no clearing pass.
module member_list_add_delete_diff_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mlad_in_if.sink     i_req,
    mlad_out_if.source  o_res
);

    mlad_pkg::t_list_ctl           w_old_ctl;
    mlad_pkg::t_list_ctl           w_new_ctl;
    logic [mlad_pkg::UID_W-1:0]    w_old_data;
    logic [mlad_pkg::UID_W-1:0]    w_new_data;
    logic [mlad_pkg::CNT_W-1:0]    w_old_cnt;
    logic [mlad_pkg::CNT_W-1:0]    w_new_cnt;
    logic [mlad_pkg::UID_W-1:0]    w_cmp_a;
    logic [mlad_pkg::UID_W-1:0]    w_cmp_b;
    mlad_pkg::t_cmp_res            w_cmp;
    mlad_pkg::t_emit               w_emit;
    logic                          w_emit_ready;
    logic                          w_in_ready;

    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [mlad_pkg::KIND_W-1:0]   r_out_kind;
    logic [mlad_pkg::UID_W-1:0]    r_out_uid;
    logic                          r_out_ovf;
    logic                          r_out_last;

    mlad_list u_old (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_old_ctl),
        .o_rd_data (w_old_data),
        .o_count   (w_old_cnt)
    );

    mlad_list u_new (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_new_ctl),
        .o_rd_data (w_new_data),
        .o_count   (w_new_cnt)
    );

    mlad_cmp u_cmp (
        .i_a   (w_cmp_a),
        .i_b   (w_cmp_b),
        .o_res (w_cmp)
    );

    mlad_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_req.valid),
        .i_op         (i_req.operation),
        .i_uid        (i_req.member_uid),
        .o_in_ready   (w_in_ready),
        .i_old_data   (w_old_data),
        .i_new_data   (w_new_data),
        .i_old_cnt    (w_old_cnt),
        .i_new_cnt    (w_new_cnt),
        .o_old_ctl    (w_old_ctl),
        .o_new_ctl    (w_new_ctl),
        .o_cmp_a      (w_cmp_a),
        .o_cmp_b      (w_cmp_b),
        .i_cmp        (w_cmp),
        .o_emit       (w_emit),
        .i_emit_ready (w_emit_ready)
    );

    assign w_emit_ready = !r_out_valid || o_res.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit.valid && w_emit_ready) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit.valid && w_emit_ready) begin
            r_out_kind <= w_emit.kind;
            r_out_uid  <= w_emit.uid;
            r_out_ovf  <= w_emit.overflowed;
            r_out_last <= w_emit.last;
        end
    end

    assign i_req.ready       = w_in_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.change_kind = r_out_kind;
    assign o_res.changed_uid = r_out_uid;
    assign o_res.overflowed  = r_out_ovf;
    assign o_res.last_result = r_out_last;

endmodule
